FILE: rtl/sopt_pkg.sv
// Package for the segment:offset pointer translator.
// Holds payload structs, mode and status codes, and default sizes.
// No dependencies.
package sopt_pkg;

	localparam int SEG_BITS_DEF    = 8;
	localparam int OFFSET_BITS_DEF = 24;

	typedef enum logic [2:0] {
		MODE_ALLOC   = 3'd0,
		MODE_RELEASE = 3'd1,
		MODE_DECODE  = 3'd2,
		MODE_ENCODE  = 3'd3,
		MODE_SHIFT   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [63:0]        address;
		logic [31:0]        packed_in;
		logic signed [63:0] shift;
	} in_item_t;

	typedef struct packed {
		logic [63:0] address_out;
		logic [31:0] packed_out;
		logic        is_null;
		logic [1:0]  status;
	} out_item_t;

	// Classified command handed from front to back.
	typedef struct packed {
		logic [2:0]  mode;
		logic        known;
		logic [63:0] address;
		logic [31:0] packed_in;
		logic [63:0] shift;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DEC,
		BK_ADD,
		BK_ENC,
		BK_DONE
	} bk_state_t;

endpackage

FILE: rtl/sopt_front.sv
// Front end: input beat acceptance, mode check, command queue toward the back end.
// Depends on sopt_pkg.
module sopt_front
	import sopt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t in_item,
	input  logic     push,
	output logic     full,
	output cmd_t     cmd,
	output logic     cmd_valid,
	input  logic     cmd_take
);

	cmd_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       do_push, do_pop;
	cmd_t       c;

	assign full      = cnt_q == 2'd2;
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cnt_q != 2'd0;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = slot_q[rp_q];

	// Classify the incoming beat
	always_comb begin
		c.mode      = in_item.mode;
		c.known     = in_item.mode <= MODE_SHIFT;
		c.address   = in_item.address;
		c.packed_in = in_item.packed_in;
		c.shift     = in_item.shift;
	end

	// Store payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= c;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: rtl/sopt_back.sv
// Back end: segment table, free stack, scan sequencer and result register.
// Depends on sopt_pkg.
module sopt_back
	import sopt_pkg::*;
#(
	parameter int SEG_BITS    = SEG_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_take,
	output out_item_t res,
	output logic      empty,
	input  logic      pop
);

	localparam int SEG_COUNT = 1 << SEG_BITS;
	localparam logic [SEG_BITS:0] FRESH_LIMIT = (SEG_BITS+1)'(SEG_COUNT - 1);
	localparam logic [63:0] OFF_MASK = (64'd1 << OFFSET_BITS) - 64'd1;

	logic [63:0]       base_mem [SEG_COUNT];
	logic [SEG_BITS-1:0] stack_mem [SEG_COUNT];
	logic [SEG_COUNT-1:0] live_q;
	logic [SEG_BITS:0] free_count_q, next_fresh_q;

	bk_state_t         state_q, state_d;
	cmd_t              c_q;
	logic [SEG_BITS:0] idx_q;
	logic [63:0]       rd_base_q;
	logic              rd_live_q, rd_vld_q;
	logic [SEG_BITS-1:0] rd_seg_q;
	logic [SEG_BITS-1:0] hit_q, best_q;
	logic [63:0]       best_base_q;
	logic              any_q, hit_vld_q, best_vld_q;
	logic [63:0]       target_q;
	logic [63:0]       dec_base_q;
	logic [SEG_BITS-1:0] stk_top_q;
	out_item_t         res_q;
	logic              full_q;

	logic [SEG_BITS-1:0] rd_addr;
	logic [SEG_BITS-1:0] dseg;
	logic [63:0]       delta;
	logic [SEG_BITS-1:0] new_seg;
	logic              have_new;
	logic [SEG_BITS:0] fc_dec;

	assign empty    = !full_q;
	assign res      = res_q;
	assign cmd_take = state_q == BK_IDLE && cmd_valid && !full_q;
	assign dseg     = c_q.packed_in[OFFSET_BITS +: SEG_BITS];
	assign rd_addr  = idx_q[SEG_BITS-1:0];
	assign delta    = target_q - best_base_q;
	assign fc_dec   = free_count_q - 1'b1;

	// Pick the segment an allocate would take
	always_comb begin
		have_new = 1'b1;
		new_seg  = stk_top_q;
		if (free_count_q == '0) begin
			new_seg = next_fresh_q[SEG_BITS-1:0];
			if (next_fresh_q >= FRESH_LIMIT) have_new = 1'b0;
		end
	end

	// Read table port, one entry per cycle; fetch the decode base while taking a command
	always_ff @(posedge clk) begin
		rd_base_q <= base_mem[rd_addr];
		rd_seg_q  <= rd_addr;
		if (state_q == BK_IDLE)
			dec_base_q <= base_mem[cmd.packed_in[OFFSET_BITS +: SEG_BITS]];
		stk_top_q <= stack_mem[fc_dec[SEG_BITS-1:0]];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (cmd_take) state_d = BK_DEC;
			BK_DEC: begin
				if (!c_q.known || c_q.mode == MODE_DECODE) state_d = BK_DONE;
				else if (c_q.mode == MODE_SHIFT) state_d = BK_ADD;
				else state_d = BK_SCAN;
			end
			BK_ADD:  state_d = BK_SCAN;
			BK_SCAN: if (idx_q == (SEG_BITS+1)'(SEG_COUNT) && !rd_vld_q) state_d = BK_ENC;
			BK_ENC:  state_d = BK_DONE;
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Sequencer, scan and table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			live_q       <= '0;
			free_count_q <= '0;
			next_fresh_q <= (SEG_BITS+1)'(1);
			full_q       <= 1'b0;
			idx_q        <= '0;
			rd_vld_q     <= 1'b0;
			rd_live_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (full_q && pop) full_q <= 1'b0;
			rd_vld_q  <= 1'b0;
			rd_live_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					idx_q <= (SEG_BITS+1)'(1);
				end
				BK_SCAN: begin
					if (idx_q < (SEG_BITS+1)'(SEG_COUNT)) begin
						rd_vld_q  <= 1'b1;
						rd_live_q <= live_q[rd_addr];
						idx_q     <= idx_q + 1'b1;
					end
				end
				BK_DONE: begin
					full_q <= 1'b1;
					if (c_q.mode == MODE_ALLOC && !hit_vld_q && have_new) begin
						live_q[new_seg] <= 1'b1;
						if (free_count_q != '0) free_count_q <= fc_dec;
						else next_fresh_q <= next_fresh_q + 1'b1;
					end
					if (c_q.mode == MODE_RELEASE && hit_vld_q) begin
						live_q[hit_q] <= 1'b0;
						free_count_q  <= free_count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Memory writes on table updates
	always_ff @(posedge clk) begin
		if (state_q == BK_DONE) begin
			if (c_q.mode == MODE_ALLOC && !hit_vld_q && have_new)
				base_mem[new_seg] <= c_q.address;
			if (c_q.mode == MODE_RELEASE && hit_vld_q)
				stack_mem[free_count_q[SEG_BITS-1:0]] <= hit_q;
		end
	end

	// Datapath: capture command, decode, compare scanned entries, build result
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				c_q        <= cmd;
				any_q      <= 1'b0;
				hit_vld_q  <= 1'b0;
				best_vld_q <= 1'b0;
				hit_q      <= '0;
			end
			BK_DEC: begin
				target_q <= c_q.address;
				if (c_q.mode == MODE_DECODE || c_q.mode == MODE_SHIFT) begin
					if (c_q.packed_in == '0 || !live_q[dseg]) target_q <= '0;
					else target_q <= dec_base_q + (64'(c_q.packed_in) & OFF_MASK);
				end
			end
			BK_ADD: target_q <= target_q + c_q.shift;
			BK_SCAN: begin
				if (rd_vld_q && rd_live_q) begin
					any_q <= 1'b1;
					if (!hit_vld_q && rd_base_q == target_q) begin
						hit_vld_q <= 1'b1;
						hit_q     <= rd_seg_q;
					end
					if (rd_base_q <= target_q &&
					    (!best_vld_q || rd_base_q > best_base_q)) begin
						best_vld_q  <= 1'b1;
						best_q      <= rd_seg_q;
						best_base_q <= rd_base_q;
					end
				end
			end
			BK_ENC: ;
			BK_DONE: begin
				res_q <= '0;
				case (c_q.mode)
					MODE_ALLOC: begin
						if (hit_vld_q || have_new) begin
							res_q.address_out <= c_q.address;
							res_q.packed_out  <= 32'(64'(hit_vld_q ? hit_q : new_seg)
							                     << OFFSET_BITS);
						end else begin
							res_q.status  <= ST_NO_FREE;
							res_q.is_null <= 1'b1;
						end
					end
					MODE_RELEASE: if (!hit_vld_q) res_q.status <= ST_UNKNOWN;
					MODE_DECODE: begin
						res_q.address_out <= target_q;
						res_q.is_null <= c_q.packed_in == '0 || !live_q[dseg];
					end
					MODE_ENCODE, MODE_SHIFT: begin
						res_q.address_out <= target_q;
						res_q.is_null     <= 1'b1;
						if (!any_q) res_q.status <= ST_EMPTY;
						else if (best_vld_q && best_q != '0 && delta <= OFF_MASK) begin
							res_q.packed_out <= 32'((64'(best_q) << OFFSET_BITS)
							                    | (delta & OFF_MASK));
							res_q.is_null    <= 32'((64'(best_q) << OFFSET_BITS)
							                    | (delta & OFF_MASK)) == '0;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/segment_offset_pointer_translator_unit.sv
// Segment:offset pointer translator: one item at a time. Decode and unused modes skip the
// table scan; allocate, release and encode scan the segment base table, one entry per
// cycle, and shift first adds its shift amount to the target. A two-entry command queue
// sits before the scan sequencer and a result register after it, so the input accepts
// beats while a result waits.
// Depends on sopt_pkg, sopt_front and sopt_back.
module segment_offset_pointer_translator_unit
	import sopt_pkg::*;
#(
	parameter int SEG_BITS    = SEG_BITS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      push,
	output logic      full,
	output out_item_t out_item,
	output logic      empty,
	input  logic      pop
);

	cmd_t cmd;
	logic cmd_valid, cmd_take;

	sopt_front u_front (
		.clk, .arst_n, .in_item, .push, .full,
		.cmd, .cmd_valid, .cmd_take
	);

	sopt_back #(.SEG_BITS(SEG_BITS), .OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take,
		.res(out_item), .empty, .pop
	);

endmodule

FILE: rtl/sopt_checker.sv
// Port-level checker for the translator, attached by bind.
// Depends on sopt_pkg.
module sopt_checker
	import sopt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t out_item
);

	// A waiting result beat holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result changed while waiting");

	// Null results never carry a pointer
	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.is_null |-> out_item.packed_out == '0)
		else $error("null result with pointer");

	// Status codes other than ok flag null or unknown release only
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_item.status == ST_NO_FREE || out_item.status == ST_EMPTY)
		|-> out_item.is_null)
		else $error("failed status without null");

	// A result cannot appear the cycle after a pop without new work
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop |=> empty)
		else $error("result repeated");

endmodule

bind segment_offset_pointer_translator_unit sopt_checker u_chk (
	.clk, .arst_n, .empty, .pop, .out_item
);
